// File: design/wcte_pkg.sv
// shared types and constants for the wrapping counter tick extender
`timescale 1ns / 1ps

package wcte_pkg;

    // fixed field widths
    localparam int TICK_W      = 64;
    localparam int FREQ_W      = 24;
    localparam int HZ_W        = 20;
    localparam int TIME_W      = 32;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    // scaling product and shared divider
    localparam int PROD_W      = TICK_W + HZ_W;
    localparam int ARM_PROD_W  = TIME_W + FREQ_W;
    localparam int DIV_CYCLES  = PROD_W / 2;
    localparam int CNT_W       = $clog2(DIV_CYCLES);

    localparam logic [FREQ_W-1:0] USECS_PER_SEC = FREQ_W'(1000 * 1000);

    // result beat: system_ticks, elapsed_ticks, delay_done, zero pad
    localparam int OUT_FIELDS_W = TICK_W + TIME_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [FREQ_W-1:0] TICK_FREQ_RESET = FREQ_W'(48828);
    localparam logic [HZ_W-1:0]   SYS_HZ_RESET    = HZ_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_FREQ = 1'b0,
        CFG_SYS_HZ    = 1'b1
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_INIT = 2'd0,
        OP_READ = 2'd1,
        OP_ARM  = 2'd2,
        OP_POLL = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM_MUL,
        ST_ARM_LOAD,
        ST_ARM_DIV,
        ST_ARM_ADD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCL_LOAD,
        ST_SCL_DIV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic arm_mul;
        logic div_load;
        logic div_sel_arm;
        logic div_step;
        logic arm_add;
        logic mul_lo;
        logic mul_hi;
        logic load_out;
    } t_dp_cmd;

endpackage

// File: design/wcte_ctrl.sv
// sequencer for absorb, arm, scale and result steps
`timescale 1ns / 1ps

module wcte_ctrl
    import wcte_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic [OP_W-1:0] i_op,
    input  logic          i_m_ready,
    output logic          o_s_ready,
    output logic          o_m_valid,
    output t_dp_cmd       o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;
    logic               w_out_free;
    logic               w_div_last;

    assign w_accept   = (r_state == ST_IDLE) && i_s_valid;
    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_div_last = (r_cnt == CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_op) == OP_ARM) ? ST_ARM_MUL : ST_MUL_LO;
                end
            end
            ST_ARM_MUL:  n_state = ST_ARM_LOAD;
            ST_ARM_LOAD: n_state = ST_ARM_DIV;
            ST_ARM_DIV: begin
                if (w_div_last) begin
                    n_state = ST_ARM_ADD;
                end
            end
            ST_ARM_ADD:  n_state = ST_MUL_LO;
            ST_MUL_LO:   n_state = ST_MUL_HI;
            ST_MUL_HI:   n_state = ST_SCL_LOAD;
            ST_SCL_LOAD: n_state = ST_SCL_DIV;
            ST_SCL_DIV: begin
                if (w_div_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands and counters
    always_comb begin
        o_cmd       = '0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_ready;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = w_accept;
            end
            ST_ARM_MUL: begin
                o_cmd.arm_mul = 1'b1;
            end
            ST_ARM_LOAD: begin
                o_cmd.div_load    = 1'b1;
                o_cmd.div_sel_arm = 1'b1;
                n_cnt             = '0;
            end
            ST_ARM_DIV, ST_SCL_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            ST_ARM_ADD: begin
                o_cmd.arm_add = 1'b1;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
            end
            ST_SCL_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

// File: design/wcte_dp.sv
// tick state, config registers, multiplier, shared divider and result register
`timescale 1ns / 1ps

module wcte_dp
    import wcte_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [OP_W-1:0]         i_op,
    input  logic [COUNTER_BITS-1:0] i_counter_value,
    input  logic [TIME_W-1:0]       i_base_time,
    input  logic [TIME_W-1:0]       i_delay_usecs,
    output logic [TICK_W-1:0]       o_system_ticks,
    output logic [TIME_W-1:0]       o_elapsed_ticks,
    output logic                    o_delay_done
);

    logic [FREQ_W-1:0]       r_tick_freq;
    logic [HZ_W-1:0]         r_sys_hz;
    logic [TICK_W-1:0]       r_tick_total;
    logic [COUNTER_BITS-1:0] r_prev_count;
    logic [TICK_W-1:0]       r_delay_target;

    logic [TIME_W-1:0]       r_base;
    logic [TIME_W-1:0]       r_usecs;
    logic [PROD_W-1:0]       r_prod;
    logic [PROD_W-1:0]       r_dvd;
    logic [FREQ_W-1:0]       r_rem;
    logic [FREQ_W-1:0]       r_den;

    logic [TICK_W-1:0]       r_sys;
    logic [TIME_W-1:0]       r_elapsed;
    logic                    r_done;

    logic [COUNTER_BITS-1:0] w_up;
    logic [COUNTER_BITS-1:0] w_delta;
    logic [ARM_PROD_W-1:0]   w_arm_prod;
    logic [TIME_W+HZ_W-1:0]  w_mul_lo;
    logic [TIME_W+HZ_W-1:0]  w_mul_hi;
    logic [TICK_W:0]         w_target_sum;
    logic [FREQ_W-1:0]       w_scale_den;
    logic [FREQ_W:0]         w_step1;
    logic [FREQ_W:0]         w_step2;

    // one restoring step: quotient bit on top, new remainder below
    function automatic logic [FREQ_W:0] f_div_step(
        input logic [FREQ_W-1:0] rem,
        input logic              din,
        input logic [FREQ_W-1:0] den
    );
        logic [FREQ_W:0] t;
        logic [FREQ_W:0] d;
        t = {rem, din};
        d = {1'b0, den};
        if (t >= d) begin
            f_div_step = {1'b1, FREQ_W'(t - d)};
        end else begin
            f_div_step = {1'b0, t[FREQ_W-1:0]};
        end
    endfunction

    // down count inverted to an up count; distance wraps at the counter width
    assign w_up    = ~i_counter_value;
    assign w_delta = w_up - r_prev_count;

    assign w_arm_prod   = r_usecs * r_tick_freq;
    assign w_mul_lo     = r_tick_total[TIME_W-1:0] * r_sys_hz;
    assign w_mul_hi     = r_tick_total[TICK_W-1:TIME_W] * r_sys_hz;
    assign w_target_sum = {1'b0, r_tick_total} + {1'b0, r_dvd[TICK_W-1:0]};
    assign w_scale_den  = (r_tick_freq == '0) ? FREQ_W'(1) : r_tick_freq;

    assign w_step1 = f_div_step(r_rem, r_dvd[PROD_W-1], r_den);
    assign w_step2 = f_div_step(w_step1[FREQ_W-1:0], r_dvd[PROD_W-2], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_freq    <= TICK_FREQ_RESET;
            r_sys_hz       <= SYS_HZ_RESET;
            r_tick_total   <= '0;
            r_prev_count   <= '0;
            r_delay_target <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TICK_FREQ: r_tick_freq <= i_cfg_wdata;
                    CFG_SYS_HZ:    r_sys_hz    <= i_cfg_wdata[HZ_W-1:0];
                    default:       r_tick_freq <= r_tick_freq;
                endcase
            end
            if (i_cmd.accept) begin
                r_prev_count <= w_up;
                if (t_op'(i_op) == OP_INIT) begin
                    r_tick_total <= '0;
                end else begin
                    r_tick_total <= r_tick_total + TICK_W'(w_delta);
                end
            end
            if (i_cmd.arm_add) begin
                r_delay_target <= w_target_sum[TICK_W] ? '1 : w_target_sum[TICK_W-1:0];
            end
        end
    end

    // work registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base  <= i_base_time;
            r_usecs <= i_delay_usecs;
        end
        if (i_cmd.arm_mul) begin
            r_prod <= PROD_W'(w_arm_prod);
        end else if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(w_mul_lo);
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + {w_mul_hi, {TIME_W{1'b0}}};
        end
        if (i_cmd.div_load) begin
            r_dvd <= r_prod;
            r_rem <= '0;
            r_den <= i_cmd.div_sel_arm ? USECS_PER_SEC : w_scale_den;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[PROD_W-3:0], w_step1[FREQ_W], w_step2[FREQ_W]};
            r_rem <= w_step2[FREQ_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_sys     <= r_dvd[TICK_W-1:0];
            r_elapsed <= r_dvd[TIME_W-1:0] - r_base;
            r_done    <= (r_tick_total >= r_delay_target);
        end
    end

    assign o_system_ticks  = r_sys;
    assign o_elapsed_ticks = r_elapsed;
    assign o_delay_done    = r_done;

endmodule

// File: design/wrapping_counter_tick_extender.sv
// top level of the wrapping counter tick extender
`timescale 1ns / 1ps

// Extends a free-running hardware down counter into a 64-bit tick count.
// Input stream: each beat carries a fresh counter reading, a base time and a
// delay in microseconds; tuser carries the operation (init, read, arm, poll).
// Result stream: one beat per input beat with the tick count scaled to the
// system rate, the time elapsed since the base, and the delay-reached flag.
// Config port: write tick_frequency (index 0) or system_hz (index 1) while
// the block is idle; writes take effect at the clock edge.
// Read, poll and init run the shared radix-4 divider once, for the scaling;
// arm runs it twice, first for the microsecond conversion and then for the
// scaling. One beat is processed at a time: a new input beat is taken only
// once the block is back to idle after the previous one.
// A finished result sits in the output register; the next input beat is
// taken while it waits, but that beat's result is held back until the
// receiver takes the earlier one.
// Reset clears the tick total, last reading and delay target, restores the
// config registers to their defaults and drops any pending result.

module wrapping_counter_tick_extender
    import wcte_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // counter_value, base_time, delay_usecs, zero pad
    input  logic [((COUNTER_BITS + 2*TIME_W + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]         i_s_axis_tuser,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // system_ticks, elapsed_ticks, delay_done, zero pad
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    t_dp_cmd           w_cmd;
    logic [TICK_W-1:0] w_system_ticks;
    logic [TIME_W-1:0] w_elapsed_ticks;
    logic              w_delay_done;

    wcte_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser),
        .i_m_ready (i_m_axis_tready),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    wcte_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_s_axis_tuser),
        .i_counter_value (i_s_axis_tdata[COUNTER_BITS-1:0]),
        .i_base_time     (i_s_axis_tdata[COUNTER_BITS+TIME_W-1:COUNTER_BITS]),
        .i_delay_usecs   (i_s_axis_tdata[COUNTER_BITS+2*TIME_W-1:COUNTER_BITS+TIME_W]),
        .o_system_ticks  (w_system_ticks),
        .o_elapsed_ticks (w_elapsed_ticks),
        .o_delay_done    (w_delay_done)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({w_delay_done, w_elapsed_ticks, w_system_ticks});

endmodule

// File: design/wcte_chk.sv
// port-level checks for the wrapping counter tick extender
`timescale 1ns / 1ps

module wcte_chk
    import wcte_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic w_in_beat;

    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // one beat in flight: no second input beat straight after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_s_axis_tready)
        else $error("input taken while an item is still in work");

    // a result never appears within a few cycles of an input beat
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(w_in_beat, 1) && !$past(w_in_beat, 2)
            && !$past(w_in_beat, 3))
        else $error("result faster than the scaling divider allows");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind wrapping_counter_tick_extender wcte_chk u_wcte_chk (.*);

// File: tb/wrapping_counter_tick_extender_tb.sv
// self-checking testbench for the wrapping counter tick extender
`timescale 1ns / 1ps

module wrapping_counter_tick_extender_tb;
    import wcte_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int S_TDATA_W    = ((COUNT_BITS + 2*TIME_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 165;
    localparam int DIRECTED_N   = 16;

    typedef struct packed {
        logic [TICK_W-1:0] sys;
        logic [TIME_W-1:0] elapsed;
        logic              done;
    } t_tick_result;

    typedef struct packed {
        t_op                   op;
        logic [COUNT_BITS-1:0] raw;
        logic [TIME_W-1:0]     base;
        logic [TIME_W-1:0]     usecs;
        logic                  typed;
        t_tick_result          res;
    } t_reading_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // counter_value, base_time, delay_usecs
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    // operation
    logic [OP_W-1:0]        i_s_axis_tuser = OP_READ;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // system_ticks, elapsed_ticks, delay_done, zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_TICK_FREQ;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    wrapping_counter_tick_extender #(
        .COUNTER_BITS(COUNT_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // own copy of the block state and registers
    logic [TICK_W-1:0]     tick_total;
    logic [COUNT_BITS-1:0] last_up_count;
    logic [TICK_W-1:0]     delay_target;
    logic [FREQ_W-1:0]     tick_freq_reg;
    logic [HZ_W-1:0]       sys_hz_reg;

    t_tick_result          expected_ticks[$];
    t_tick_result          want_res;
    t_tick_result          got_res;
    int                    err_count = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    ready_hold = 0;
    logic [COUNT_BITS-1:0] last_raw = '0;
    logic [TICK_W-1:0]     last_sys = '0;

    t_reading_row          directed_rows[DIRECTED_N];
    logic [FREQ_W-1:0]     phase_freq[PHASE_COUNT];
    logic [HZ_W-1:0]       phase_hz[PHASE_COUNT];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic advance_tick_count(input t_op op, input logic [COUNT_BITS-1:0] raw,
                                      input logic [TIME_W-1:0] base,
                                      input logic [TIME_W-1:0] usecs,
                                      output t_tick_result res);
        logic [COUNT_BITS-1:0] up;
        logic [COUNT_BITS-1:0] step;
        logic [TICK_W-1:0]     arm_add;
        logic [TICK_W:0]       arm_sum;
        logic [PROD_W-1:0]     scaled;
        logic [FREQ_W-1:0]     divisor;
        up = ~raw;
        step = up - last_up_count;
        tick_total = tick_total + TICK_W'(step);
        last_up_count = up;
        if (op == OP_INIT) begin
            tick_total = '0;
        end else if (op == OP_ARM) begin
            arm_add = (TICK_W'(usecs) * TICK_W'(tick_freq_reg)) / TICK_W'(USECS_PER_SEC);
            arm_sum = {1'b0, tick_total} + {1'b0, arm_add};
            delay_target = arm_sum[TICK_W] ? '1 : arm_sum[TICK_W-1:0];
        end
        // zero frequency divides by one
        divisor = (tick_freq_reg == '0) ? FREQ_W'(1) : tick_freq_reg;
        scaled = (PROD_W'(tick_total) * PROD_W'(sys_hz_reg)) / PROD_W'(divisor);
        res.sys = scaled[TICK_W-1:0];
        res.elapsed = res.sys[TIME_W-1:0] - base;
        res.done = (tick_total >= delay_target);
    endtask

    task automatic send_reading(input t_op op, input logic [COUNT_BITS-1:0] raw,
                                input logic [TIME_W-1:0] base,
                                input logic [TIME_W-1:0] usecs,
                                input logic typed, input t_tick_result typed_res);
        t_tick_result pred;
        int           gap;
        int unsigned  pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 20);
            else
                gap = $urandom_range(21, 100);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {usecs, base, raw};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_tick_count(op, raw, base, usecs, pred);
        expected_ticks.push_back(typed ? typed_res : pred);
        last_sys = pred.sys;
        last_raw = raw;
    endtask

    task automatic wait_drained;
        i_s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_TICK_FREQ)
            tick_freq_reg = val;
        else
            sys_hz_reg = val[HZ_W-1:0];
    endtask

    task automatic run_random_readings(input int count);
        t_op                   op;
        logic [COUNT_BITS-1:0] raw;
        logic [TIME_W-1:0]     base;
        logic [TIME_W-1:0]     usecs;
        int unsigned           pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                op = OP_INIT;
            else if (pick < 40)
                op = OP_READ;
            else if (pick < 55)
                op = OP_ARM;
            else
                op = OP_POLL;
            // mostly a counter running down between polls, sometimes a jump
            pick = $urandom_range(0, 99);
            if (pick < 55)
                raw = last_raw - COUNT_BITS'($urandom_range(0, 400));
            else if (pick < 60)
                raw = last_raw;
            else
                raw = COUNT_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                base = $urandom;
            else
                base = last_sys[TIME_W-1:0] - TIME_W'($urandom_range(0, 1000));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                usecs = $urandom_range(0, 20000);
            else if (pick < 85)
                usecs = $urandom_range(0, 2000000);
            else
                usecs = $urandom;
            send_reading(op, raw, base, usecs, 1'b0, '0);
        end
    endtask

    // result side: check every beat taken, then pick the next stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_res.sys     = o_m_axis_tdata[TICK_W-1:0];
            got_res.elapsed = o_m_axis_tdata[TICK_W +: TIME_W];
            got_res.done    = o_m_axis_tdata[TICK_W + TIME_W];
            if (expected_ticks.size() == 0) begin
                $error("result beat with no expected result waiting");
                err_count++;
            end else begin
                want_res = expected_ticks.pop_front();
                if (got_res.sys !== want_res.sys) begin
                    $error("system_ticks: expected %0h actual %0h", want_res.sys, got_res.sys);
                    err_count++;
                end
                if (got_res.elapsed !== want_res.elapsed) begin
                    $error("elapsed_ticks: expected %0h actual %0h",
                           want_res.elapsed, got_res.elapsed);
                    err_count++;
                end
                if (got_res.done !== want_res.done) begin
                    $error("delay_done: expected %0b actual %0b", want_res.done, got_res.done);
                    err_count++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    i_m_axis_tready <= 1'b1;
                    ready_hold <= $urandom_range(1, 30);
                end
                5, 6, 7: begin
                    i_m_axis_tready <= 1'b0;
                    ready_hold <= $urandom_range(1, 12);
                end
                default: begin
                    i_m_axis_tready <= 1'b0;
                    ready_hold <= $urandom_range(13, 40);
                end
            endcase
        end
    end

    initial begin
        tick_total    = '0;
        last_up_count = '0;
        delay_target  = '0;
        tick_freq_reg = TICK_FREQ_RESET;
        sys_hz_reg    = SYS_HZ_RESET;

        // defaults 48828 / 1000; typed rows follow from a zero or cleared total
        directed_rows = '{
            '{OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{64'd0, 32'd1, 1'b1}},
            '{OP_READ, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_POLL, 16'h0000, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
            // reading goes up again: the counter wrapped by one tick
            '{OP_ARM,  16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_POLL, 16'h8000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{OP_READ, 16'h0001, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
            '{OP_INIT, 16'h1234, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{64'd0, 32'd0, 1'b0}},
            '{OP_POLL, 16'h1234, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{64'd0, 32'd0, 1'b0}},
            '{OP_ARM,  16'h1234, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{64'd0, 32'd0, 1'b1}},
            '{OP_READ, 16'h1233, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_ARM,  16'h0000, 32'h5555_5555, 32'd1000000, 1'b0, '0},
            '{OP_POLL, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_POLL, 16'h8000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_POLL, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{OP_READ, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_INIT, 16'hFFFF, 32'h8000_0000, 32'h0000_0000, 1'b1,
              '{64'd0, 32'h8000_0000, 1'b0}}
        };

        // extremes first, then zero frequency, zero system rate, then random
        phase_freq[0] = 24'hFF_FFFF;  phase_hz[0] = 20'd1000000;
        phase_freq[1] = 24'd1;        phase_hz[1] = 20'd1;
        phase_freq[2] = 24'd1;        phase_hz[2] = 20'd1000000;
        phase_freq[3] = 24'hFF_FFFF;  phase_hz[3] = 20'd1;
        phase_freq[4] = 24'd0;        phase_hz[4] = 20'd1000000;
        phase_freq[5] = 24'd48828;    phase_hz[5] = 20'd0;
        for (int p = 6; p < PHASE_COUNT; p++) begin
            phase_freq[p] = FREQ_W'($urandom_range(1, 24'hFF_FFFF));
            phase_hz[p]   = HZ_W'($urandom_range(1, 1000000));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_N; r++)
            send_reading(directed_rows[r].op, directed_rows[r].raw, directed_rows[r].base,
                         directed_rows[r].usecs, directed_rows[r].typed,
                         directed_rows[r].res);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            write_cfg(CFG_TICK_FREQ, phase_freq[p]);
            write_cfg(CFG_SYS_HZ, CFG_DATA_W'(phase_hz[p]));
            i_cfg_we <= 1'b0;
            run_random_readings(PHASE_ITEMS);
        end

        wait_drained();
        repeat (120) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
